/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the lexer RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// clocked check with explicit clock and active-low reset
`define ASSERT_CLKD(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("%m: check failed");

// clocked check on the house clock and reset
`define ASSERT_STD(label, prop) \
	`ASSERT_CLKD(label, clk, arst_n, prop)

`else

`define ASSERT_CLKD(label, clk, rst_n, prop)
`define ASSERT_STD(label, prop)

`endif

`endif

/* rtl/asmlex_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmlex_pkg
// Shared types, codes and constants of the assembly source lexer.
// ----------------------------------------------------------------------------
package asmlex_pkg;

	localparam int MAX_IDENT_CHARS_DEF = 8;
	localparam int POSITION_BITS_DEF   = 16;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LPAR  = 8'h28;
	localparam logic [7:0] CH_RPAR  = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_UPX   = 8'h58;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_LOWX  = 8'h78;

	typedef enum logic [3:0] {
		TK_IDENT   = 4'd0,
		TK_NEWLINE = 4'd1,
		TK_COLON   = 4'd2,
		TK_COMMA   = 4'd3,
		TK_NUMBER  = 4'd4,
		TK_OPEN    = 4'd5,
		TK_CLOSE   = 4'd6,
		TK_END     = 4'd7,
		TK_BAD     = 4'd8,
		TK_RANGE   = 4'd9
	} kind_t;

	typedef enum logic [2:0] {
		MD_IDLE    = 3'd0,
		MD_COMMENT = 3'd1,
		MD_IDENT   = 3'd2,
		MD_NUMBER  = 3'd3,
		MD_HALTED  = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		RDX_DEC = 2'd0,
		RDX_OCT = 2'd1,
		RDX_HEX = 2'd2
	} radix_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] char_code;
		logic       eoi;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] line;
		logic [15:0] column;
		logic [30:0] value;
		logic [63:0] text;
		logic [3:0]  length;
		logic        trunc;
		logic        last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     tok0;
		token_t     tok1;
	} push_t;

endpackage

/* rtl/asmlex_in_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmlex_in_stage
// Input register for source bytes; refills in the cycle the lexer consumes.
// ----------------------------------------------------------------------------
module asmlex_in_stage import asmlex_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,
	input  logic       consume,
	output in_item_t   item
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	assign s_tready = !valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tlast;
		end
	end

	assign item = '{valid: valid_s1, char_code: char_s1, eoi: eoi_s1};

endmodule

/* rtl/asmlex_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmlex_scan
// Lexer state and per-byte token logic; yields up to two tokens per byte.
// ----------------------------------------------------------------------------
module asmlex_scan import asmlex_pkg::*; #(
	parameter int MAX_IDENT_CHARS = MAX_IDENT_CHARS_DEF,
	parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_item_t   item,
	input  logic [1:0] room,
	output logic       consume,
	output push_t      push
);

	localparam int NB = 8 * MAX_IDENT_CHARS;
	localparam int EW = (POSITION_BITS > 16) ? POSITION_BITS : 17;
	localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
	localparam logic [34:0] VALUE_MAX = 35'h07FFFFFFF;

	mode_t                    mode_q, mode_d;
	logic [POSITION_BITS-1:0] line_q, line_d, col_q, col_d;
	logic [POSITION_BITS-1:0] sline_q, sline_d, scol_q, scol_d;
	logic [NB-1:0]            name_q, name_d;
	logic [3:0]               cnt_q, cnt_d;
	logic                     ovf_q, ovf_d;
	logic [30:0]              acc_q, acc_d;
	radix_t                   radix_q, radix_d;
	logic                     first_q, first_d;
	logic                     halted_q, halted_d;
	logic                     big_q, big_d;

	logic [7:0] c;
	logic       eoi;
	logic       is_blank, is_semi, is_alpha, is_digit, is_start, is_word;
	logic       is_nl, is_xchar, is_hexl, num_char;
	logic [3:0] dv;
	logic       dv_ok, dig_ok;
	logic [34:0] acc_x, dv_x, v8, v10, v16, v_sel;
	mode_t      fresh_mode;
	kind_t      fresh_kind;
	logic       pend, run_fresh, go_halt, fresh_emit, femit;
	logic [1:0] n_tok;
	token_t     ptok, ftok;

	function automatic logic [15:0] clip16(input logic [POSITION_BITS-1:0] p);
		logic [EW-1:0] e;
		e = EW'(p);
		return (e > EW'(65535)) ? 16'hFFFF : e[15:0];
	endfunction

	assign c   = item.char_code;
	assign eoi = item.eoi;

	// character classes
	assign is_blank = (c == CH_SPACE) || (c == CH_TAB);
	assign is_semi  = (c == CH_SEMI);
	assign is_nl    = (c == CH_NL);
	assign is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	assign is_digit = (c >= 8'h30 && c <= 8'h39);
	assign is_start = is_alpha || (c == CH_UNDER);
	assign is_word  = is_start || is_digit;
	assign is_xchar = (c == CH_LOWX) || (c == CH_UPX);
	assign is_hexl  = (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	assign num_char = is_digit || is_hexl || is_xchar;

	always_comb begin
		dv    = 4'd0;
		dv_ok = 1'b1;
		if (is_digit) begin
			dv = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			dv = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			dv = 4'(c - 8'h37);
		end else begin
			dv_ok = 1'b0;
		end
	end

	always_comb begin
		case (radix_q)
			RDX_HEX: dig_ok = dv_ok;
			RDX_OCT: dig_ok = dv_ok && (dv <= 4'd7);
			default: dig_ok = dv_ok && (dv <= 4'd9);
		endcase
	end

	assign acc_x = 35'(acc_q);
	assign dv_x  = 35'(dv);
	assign v8    = (acc_x << 3) + dv_x;
	assign v10   = (acc_x << 3) + (acc_x << 1) + dv_x;
	assign v16   = (acc_x << 4) + dv_x;

	always_comb begin
		case (radix_q)
			RDX_HEX: v_sel = v16;
			RDX_OCT: v_sel = v8;
			default: v_sel = v10;
		endcase
	end

	always_comb begin
		fresh_kind = TK_BAD;
		if (is_nl) fresh_kind = TK_NEWLINE;
		else if (c == CH_COLON) fresh_kind = TK_COLON;
		else if (c == CH_COMMA) fresh_kind = TK_COMMA;
		else if (c == CH_LPAR) fresh_kind = TK_OPEN;
		else if (c == CH_RPAR) fresh_kind = TK_CLOSE;
	end

	always_comb begin
		if (is_blank) fresh_mode = MD_IDLE;
		else if (is_semi) fresh_mode = MD_COMMENT;
		else if (is_start) fresh_mode = MD_IDENT;
		else if (is_digit) fresh_mode = MD_NUMBER;
		else if (fresh_kind != TK_BAD) fresh_mode = MD_IDLE;
		else fresh_mode = MD_HALTED;
	end

	// control decode
	always_comb begin
		pend      = 1'b0;
		run_fresh = 1'b0;
		go_halt   = 1'b0;
		if (eoi) begin
			pend = (mode_q == MD_IDENT) || (mode_q == MD_NUMBER);
		end else begin
			unique case (mode_q)
				MD_HALTED: ;
				MD_COMMENT: run_fresh = is_nl;
				MD_IDENT: begin
					pend      = !is_word;
					run_fresh = !is_word;
				end
				MD_NUMBER: begin
					if (!num_char) begin
						pend      = 1'b1;
						go_halt   = big_q;
						run_fresh = !big_q;
					end
				end
				MD_IDLE: run_fresh = 1'b1;
				default: ;
			endcase
		end
	end

	// next mode
	always_comb begin
		if (eoi) mode_d = MD_IDLE;
		else if (run_fresh) mode_d = fresh_mode;
		else if (go_halt) mode_d = MD_HALTED;
		else mode_d = mode_q;
	end

	assign fresh_emit = run_fresh && !is_blank && !is_semi && !is_start && !is_digit;
	assign femit      = eoi || fresh_emit;
	assign n_tok      = {1'b0, pend} + {1'b0, femit};
	assign consume    = item.valid && (n_tok <= room);

	always_comb begin
		ptok        = '0;
		ptok.kind   = (mode_q == MD_IDENT) ? TK_IDENT : (big_q ? TK_RANGE : TK_NUMBER);
		ptok.line   = clip16(sline_q);
		ptok.column = clip16(scol_q);
		ptok.last   = !femit;
		if (mode_q == MD_IDENT) begin
			ptok.text   = 64'(name_q);
			ptok.length = cnt_q;
			ptok.trunc  = ovf_q;
		end else if (!big_q) begin
			ptok.value = acc_q;
		end
		ftok        = '0;
		ftok.kind   = eoi ? TK_END : fresh_kind;
		ftok.line   = clip16(line_q);
		ftok.column = clip16(col_q);
		ftok.last   = 1'b1;
	end

	assign push = '{count: n_tok, tok0: (pend ? ptok : ftok), tok1: ftok};

	// datapath next values
	always_comb begin
		line_d   = line_q;
		col_d    = col_q;
		sline_d  = sline_q;
		scol_d   = scol_q;
		name_d   = name_q;
		cnt_d    = cnt_q;
		ovf_d    = ovf_q;
		acc_d    = acc_q;
		radix_d  = radix_q;
		first_d  = first_q;
		halted_d = halted_q;
		big_d    = big_q;
		if (eoi) begin
			line_d   = POS_ONE;
			col_d    = POS_ONE;
			sline_d  = '0;
			scol_d   = '0;
			name_d   = '0;
			cnt_d    = '0;
			ovf_d    = 1'b0;
			acc_d    = '0;
			radix_d  = RDX_DEC;
			first_d  = 1'b0;
			halted_d = 1'b0;
			big_d    = 1'b0;
		end else begin
			if (mode_q == MD_IDENT && is_word) begin
				if (cnt_q < 4'(MAX_IDENT_CHARS)) begin
					for (int i = 0; i < MAX_IDENT_CHARS; i++) begin
						if (cnt_q == 4'(i)) name_d[8*i +: 8] = c;
					end
					cnt_d = cnt_q + 4'd1;
				end else begin
					ovf_d = 1'b1;
				end
			end
			if (mode_q == MD_NUMBER && num_char) begin
				if (first_q && radix_q == RDX_OCT && is_xchar) begin
					radix_d = RDX_HEX;
					first_d = 1'b0;
				end else begin
					first_d = 1'b0;
					if (!halted_q && !big_q) begin
						if (!dig_ok) halted_d = 1'b1;
						else if (v_sel > VALUE_MAX) big_d = 1'b1;
						else acc_d = v_sel[30:0];
					end
				end
			end
			if (run_fresh && (is_start || is_digit)) begin
				sline_d = line_q;
				scol_d  = col_q;
			end
			if (run_fresh && is_start) begin
				name_d = NB'(c);
				cnt_d  = 4'd1;
				ovf_d  = 1'b0;
			end
			if (run_fresh && is_digit) begin
				acc_d    = 31'(dv);
				radix_d  = (c == 8'h30) ? RDX_OCT : RDX_DEC;
				first_d  = 1'b1;
				halted_d = 1'b0;
				big_d    = 1'b0;
			end
			if (is_nl) begin
				if (line_q != POS_MAX) line_d = line_q + POS_ONE;
				col_d = POS_ONE;
			end else if (col_q != POS_MAX) begin
				col_d = col_q + POS_ONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MD_IDLE;
			line_q   <= POS_ONE;
			col_q    <= POS_ONE;
			sline_q  <= '0;
			scol_q   <= '0;
			name_q   <= '0;
			cnt_q    <= '0;
			ovf_q    <= 1'b0;
			acc_q    <= '0;
			radix_q  <= RDX_DEC;
			first_q  <= 1'b0;
			halted_q <= 1'b0;
			big_q    <= 1'b0;
		end else if (consume) begin
			mode_q   <= mode_d;
			line_q   <= line_d;
			col_q    <= col_d;
			sline_q  <= sline_d;
			scol_q   <= scol_d;
			name_q   <= name_d;
			cnt_q    <= cnt_d;
			ovf_q    <= ovf_d;
			acc_q    <= acc_d;
			radix_q  <= radix_d;
			first_q  <= first_d;
			halted_q <= halted_d;
			big_q    <= big_d;
		end
	end

endmodule

/* rtl/asmlex_result_q.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmlex_result_q
// Two-slot result register; slot 0 drives the output stream.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module asmlex_result_q import asmlex_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_en,
	input  push_t        push,
	output logic [1:0]   room,
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,  // line, column, value, ident_text, ident_length,
	                               // ident_truncated, zero pad
	output logic [3:0]   m_tuser,  // token_kind
	output logic         m_tlast
);

	logic [1:0] count_q, count_d, rem;
	token_t     slot0_q, slot1_q, slot0_d, slot1_d;
	logic       pop;
	logic [1:0] n_push;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != 2'd0);
	assign room     = 2'd2 - count_q;
	assign n_push   = push_en ? push.count : 2'd0;

	always_comb begin
		rem     = count_q - {1'b0, pop};
		slot0_d = pop ? slot1_q : slot0_q;
		slot1_d = slot1_q;
		if (n_push != 2'd0) begin
			if (rem == 2'd0) slot0_d = push.tok0;
			else slot1_d = push.tok0;
		end
		if (n_push == 2'd2) slot1_d = push.tok1;
		count_d = rem + n_push;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		slot0_q <= slot0_d;
		slot1_q <= slot1_d;
	end

	assign m_tdata = {4'b0, slot0_q.trunc, slot0_q.length, slot0_q.text, slot0_q.value,
		slot0_q.column, slot0_q.line};
	assign m_tuser = slot0_q.kind;
	assign m_tlast = slot0_q.last;

	`ASSERT_STD(a_count_max, count_q <= 2'd2)
	`ASSERT_STD(a_no_overflow, ({1'b0, n_push} + {1'b0, count_q}) <= 3'd2)
	`ASSERT_STD(a_drain, (count_q == 2'd1 && pop && n_push == 2'd0) |=> !m_tvalid)
	`ASSERT_STD(a_pair_order, (n_push == 2'd2) |-> (!push.tok0.last && push.tok1.last))

endmodule

/* rtl/assembler_lexer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// assembler_lexer
// Assembly source lexer: source bytes in, positioned tokens out.
// ----------------------------------------------------------------------------
// One source byte per cycle while the result register has room. A byte is
// registered, then lexed, and its tokens land in a two-slot result register,
// from which the first token is offered on the output stream.
// A byte is taken only when the result register has room for all of its
// tokens. A byte that closes an identifier or in-range number and is itself a
// token yields two tokens, as does end of input with a token pending. Such a
// byte behind a waiting token holds the input until both slots are free. End
// of input (s_tlast) flushes a pending token, sends the end token and returns
// the position to line 1, column 1. After a bad byte or an out-of-range
// number the lexer sends nothing more until end of input. No clearing pass
// after reset.
// ----------------------------------------------------------------------------
module assembler_lexer import asmlex_pkg::*; #(
	parameter int MAX_IDENT_CHARS = MAX_IDENT_CHARS_DEF,
	parameter int POSITION_BITS   = POSITION_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [7:0]   s_tdata,   // [7:0] char_code
	input  logic         s_tlast,   // end_of_input
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // [15:0] line, [31:16] column, [62:32] value,
	                                // [126:63] ident_text, [130:127] ident_length,
	                                // [131] ident_truncated, [135:132] zero
	output logic [3:0]   m_tuser,   // [3:0] token_kind
	output logic         m_tlast    // last_of_run
);

	in_item_t   item;
	logic       consume;
	logic [1:0] room;
	push_t      push;

	asmlex_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.consume  (consume),
		.item     (item)
	);

	asmlex_scan #(
		.MAX_IDENT_CHARS (MAX_IDENT_CHARS),
		.POSITION_BITS   (POSITION_BITS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.room    (room),
		.consume (consume),
		.push    (push)
	);

	asmlex_result_q u_res (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_en  (consume),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the assembly source lexer.
// ----------------------------------------------------------------------------
// Source bytes go in as stream transfers and tokens come back on the output
// stream. Every byte the lexer takes is also run through a behavioral lexer
// in the bench. That lexer queues the tokens the byte should cause, and each
// token that comes out is compared field by field with the oldest one queued.
// The stimulus is a short directed prologue followed by random source files:
// labels, mnemonics, operands in every radix, comments and stray bytes.
// Both sides stall at random. The receiver also holds off for long stretches
// so that the input backs up.
// ----------------------------------------------------------------------------
module tb_top import asmlex_pkg::*; ();

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD   = 400;

	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
		logic       fast;   // no sender gap after this byte
		logic       drain;  // offer only once no token is outstanding
	} src_byte_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [7:0]   s_tdata = 8'd0;
	logic         s_tlast = 1'b0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [135:0] m_tdata;
	logic [3:0]   m_tuser;
	logic         m_tlast;

	src_byte_t src_q[$];
	token_t    tok_q[$];
	src_byte_t cur;

	int unsigned bytes_taken = 0;
	int unsigned bytes_total = 0;
	int          errors = 0;
	int          toks_seen = 0;
	int          gap_left = 0;
	int          hold_left = 0;
	int          quiet = 0;
	bit          tx_calm = 1'b0;
	bit          rx_calm = 1'b0;
	bit          drain_next = 1'b0;

	string WORD_HEAD = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
	string WORD_TAIL = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
	string NUM_CH    = "0123456789abcdefABCDEFxX";

	// lexer shadow state
	mode_t       lx_mode;
	logic [15:0] cur_ln, cur_col, tok_ln, tok_col;
	logic [63:0] name_buf;
	logic [3:0]  name_len;
	logic        name_long;
	logic [30:0] num_val;
	radix_t      num_base;
	logic [1:0]  num_seen;
	logic        num_stopped, num_over;
	token_t      step_tok [0:1];
	int          step_cnt;

	assembler_lexer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// behavioral lexer
	// ------------------------------------------------------------------------
	function automatic bit is_letter(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic bit is_dec(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_hex(logic [7:0] c);
		return is_dec(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic void lex_clear();
		lx_mode     = MD_IDLE;
		cur_ln      = 16'd1;
		cur_col     = 16'd1;
		tok_ln      = 16'd0;
		tok_col     = 16'd0;
		name_buf    = 64'd0;
		name_len    = 4'd0;
		name_long   = 1'b0;
		num_val     = 31'd0;
		num_base    = RDX_DEC;
		num_seen    = 2'd0;
		num_stopped = 1'b0;
		num_over    = 1'b0;
	endfunction

	function automatic void put_token(kind_t k, logic [15:0] l, logic [15:0] c,
			logic [30:0] v, logic [63:0] t, logic [3:0] n, logic tr);
		token_t tk;
		tk.kind   = k;
		tk.line   = l;
		tk.column = c;
		tk.value  = v;
		tk.text   = t;
		tk.length = n;
		tk.trunc  = tr;
		tk.last   = 1'b0;
		step_tok[step_cnt] = tk;
		step_cnt++;
	endfunction

	function automatic void put_ident();
		put_token(TK_IDENT, tok_ln, tok_col, 31'd0, name_buf, name_len, name_long);
	endfunction

	// out-of-range number replaces the token and halts the lexer
	function automatic void put_number();
		if (num_over) begin
			put_token(TK_RANGE, tok_ln, tok_col, 31'd0, 64'd0, 4'd0, 1'b0);
			lx_mode = MD_HALTED;
		end else begin
			put_token(TK_NUMBER, tok_ln, tok_col, num_val, 64'd0, 4'd0, 1'b0);
		end
	endfunction

	function automatic void begin_token(logic [7:0] c);
		if (c == CH_SPACE || c == CH_TAB)
			return;
		if (c == CH_SEMI) begin
			lx_mode = MD_COMMENT;
			return;
		end
		if (is_letter(c) || c == CH_UNDER) begin
			lx_mode   = MD_IDENT;
			tok_ln    = cur_ln;
			tok_col   = cur_col;
			name_buf  = {56'd0, c};
			name_len  = 4'd1;
			name_long = 1'b0;
			return;
		end
		if (is_dec(c)) begin
			lx_mode     = MD_NUMBER;
			tok_ln      = cur_ln;
			tok_col     = cur_col;
			num_val     = 31'(c - "0");
			num_base    = (c == "0") ? RDX_OCT : RDX_DEC;
			num_seen    = 2'd1;
			num_stopped = 1'b0;
			num_over    = 1'b0;
			return;
		end
		case (c)
			CH_NL:    put_token(TK_NEWLINE, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			CH_COLON: put_token(TK_COLON, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			CH_COMMA: put_token(TK_COMMA, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			CH_LPAR:  put_token(TK_OPEN, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			CH_RPAR:  put_token(TK_CLOSE, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			default: begin
				put_token(TK_BAD, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
				lx_mode = MD_HALTED;
			end
		endcase
	endfunction

	function automatic void feed_digit(logic [7:0] c);
		int unsigned rad;
		int unsigned d;
		logic [63:0] acc;
		// "0x" / "0X" switches the literal to hex
		if (num_seen == 2'd1 && num_base == RDX_OCT && (c == CH_LOWX || c == CH_UPX)) begin
			num_base = RDX_HEX;
			num_seen = 2'd2;
			return;
		end
		num_seen = 2'd2;
		if (num_stopped || num_over)
			return;
		rad = (num_base == RDX_HEX) ? 16 : ((num_base == RDX_OCT) ? 8 : 10);
		if (is_dec(c))
			d = c - "0";
		else if (c >= "a" && c <= "f")
			d = c - "a" + 10;
		else if (c >= "A" && c <= "F")
			d = c - "A" + 10;
		else
			d = 99;
		if (d >= rad) begin
			num_stopped = 1'b1;
			return;
		end
		acc = {33'd0, num_val};
		acc = acc * rad + d;
		if (acc > 64'h7FFF_FFFF)
			num_over = 1'b1;
		else
			num_val = acc[30:0];
	endfunction

	task automatic lex_step(input logic [7:0] c, input logic eoi);
		step_cnt = 0;
		if (eoi) begin
			if (lx_mode == MD_IDENT)
				put_ident();
			else if (lx_mode == MD_NUMBER)
				put_number();
			put_token(TK_END, cur_ln, cur_col, 31'd0, 64'd0, 4'd0, 1'b0);
			lex_clear();
		end else begin
			case (lx_mode)
				MD_HALTED: ;
				MD_COMMENT: begin
					if (c == CH_NL) begin
						lx_mode = MD_IDLE;
						begin_token(c);
					end
				end
				MD_IDENT: begin
					if (is_letter(c) || is_dec(c) || c == CH_UNDER) begin
						if (name_len < MAX_IDENT_CHARS_DEF) begin
							name_buf[8 * name_len +: 8] = c;
							name_len++;
						end else begin
							name_long = 1'b1;
						end
					end else begin
						put_ident();
						lx_mode = MD_IDLE;
						begin_token(c);
					end
				end
				MD_NUMBER: begin
					if (is_hex(c) || c == CH_LOWX || c == CH_UPX) begin
						feed_digit(c);
					end else begin
						put_number();
						if (lx_mode != MD_HALTED) begin
							lx_mode = MD_IDLE;
							begin_token(c);
						end
					end
				end
				default: begin
					lx_mode = MD_IDLE;
					begin_token(c);
				end
			endcase
			if (c == CH_NL) begin
				if (cur_ln != 16'hFFFF)
					cur_ln++;
				cur_col = 16'd1;
			end else if (cur_col != 16'hFFFF) begin
				cur_col++;
			end
		end
		for (int i = 0; i < step_cnt; i++) begin
			if (i == step_cnt - 1)
				step_tok[i].last = 1'b1;
			tok_q.insert(tok_q.size(), step_tok[i]);
		end
	endtask

	// ------------------------------------------------------------------------
	// source generation
	// ------------------------------------------------------------------------
	task automatic push_src(input logic [7:0] ch, input bit eoi, input bit fast);
		src_byte_t b;
		b.ch    = ch;
		b.eoi   = eoi;
		b.fast  = fast;
		b.drain = drain_next;
		drain_next = 1'b0;
		src_q.insert(src_q.size(), b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_src(s[i], 1'b0, 1'b0);
	endtask

	task automatic push_end();
		push_src(8'($urandom_range(0, 255)), 1'b1, 1'b0);
	endtask

	task automatic push_blanks();
		int n;
		n = $urandom_range(0, 2);
		for (int i = 0; i < n; i++)
			push_src(($urandom_range(0, 2) == 0) ? CH_TAB : CH_SPACE, 1'b0, 1'b0);
	endtask

	task automatic push_word();
		int n;
		n = $urandom_range(0, 11);
		push_src(WORD_HEAD[$urandom_range(0, WORD_HEAD.len() - 1)], 1'b0, 1'b0);
		for (int i = 0; i < n; i++)
			push_src(WORD_TAIL[$urandom_range(0, WORD_TAIL.len() - 1)], 1'b0, 1'b0);
	endtask

	task automatic push_number();
		int unsigned v;
		int          n;
		string       s;
		v = $urandom() >> $urandom_range(0, 31);
		case ($urandom_range(0, 7))
			0, 1, 2: s = $sformatf("%0d", v);
			3: begin
				if ($urandom_range(0, 1) == 0)
					s = $sformatf("0x%0h", v);
				else
					s = $sformatf("0X%0h", v);
			end
			4: s = $sformatf("0%0o", v);
			5: begin
				case ($urandom_range(0, 9))
					0: s = "2147483647";
					1: s = "2147483648";
					2: s = "0x7FFFFFFF";
					3: s = "0x80000000";
					4: s = "017777777777";
					5: s = "020000000000";
					6: s = "0x";
					7: s = "08";
					8: s = "0xx1";
					default: s = "99999999999";
				endcase
			end
			default: begin
				s = "0";
				s[0] = NUM_CH[$urandom_range(0, 9)];
				n = $urandom_range(0, 10);
				for (int i = 0; i < n; i++)
					s = {s, NUM_CH.substr($urandom_range(0, NUM_CH.len() - 1),
						$urandom_range(0, NUM_CH.len() - 1))};
			end
		endcase
		push_text(s);
	endtask

	task automatic push_operand();
		case ($urandom_range(0, 4))
			0, 1: push_number();
			2: push_word();
			default: begin
				push_src(CH_LPAR, 1'b0, 1'b0);
				if ($urandom_range(0, 1) == 0)
					push_number();
				else
					push_word();
				push_src(CH_RPAR, 1'b0, 1'b0);
			end
		endcase
	endtask

	task automatic push_line();
		int n_ops;
		int n;
		if ($urandom_range(0, 2) == 0) begin
			push_word();
			push_src(CH_COLON, 1'b0, 1'b0);
		end
		push_blanks();
		if ($urandom_range(0, 5) != 0) begin
			push_word();
			push_src(CH_SPACE, 1'b0, 1'b0);
			n_ops = $urandom_range(0, 3);
			for (int i = 0; i < n_ops; i++) begin
				if (i > 0)
					push_src(CH_COMMA, 1'b0, 1'b0);
				push_blanks();
				push_operand();
			end
		end
		if ($urandom_range(0, 24) == 0)
			push_src(8'($urandom_range(0, 255)), 1'b0, 1'b0);
		if ($urandom_range(0, 3) == 0) begin
			push_src(CH_SEMI, 1'b0, 1'b0);
			n = $urandom_range(0, 8);
			for (int i = 0; i < n; i++)
				push_src(8'($urandom_range(32, 126)), 1'b0, 1'b0);
		end
		if ($urandom_range(0, 29) == 0)
			push_src(8'h0D, 1'b0, 1'b0);
		push_src(CH_NL, 1'b0, 1'b0);
	endtask

	// ------------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(input string msg);
		errors++;
		$display("MISMATCH: %s", msg);
	endtask

	function automatic string field_msg(string name, logic [63:0] got, logic [63:0] want);
		return $sformatf("token %0d %s: got %0h, expected %0h", toks_seen, name, got, want);
	endfunction

	task automatic check_token();
		token_t want;
		if (tok_q.size() == 0) begin
			flag_mismatch($sformatf("token %0d of kind %0d with none pending",
				toks_seen, m_tuser));
			return;
		end
		want = tok_q.pop_front();
		if (m_tuser !== want.kind)
			flag_mismatch(field_msg("kind", m_tuser, want.kind));
		if (m_tdata[15:0] !== want.line)
			flag_mismatch(field_msg("line", m_tdata[15:0], want.line));
		if (m_tdata[31:16] !== want.column)
			flag_mismatch(field_msg("column", m_tdata[31:16], want.column));
		if (m_tdata[62:32] !== want.value)
			flag_mismatch(field_msg("value", m_tdata[62:32], want.value));
		if (m_tdata[126:63] !== want.text)
			flag_mismatch(field_msg("text", m_tdata[126:63], want.text));
		if (m_tdata[130:127] !== want.length)
			flag_mismatch(field_msg("length", m_tdata[130:127], want.length));
		if (m_tdata[131] !== want.trunc)
			flag_mismatch(field_msg("truncated", m_tdata[131], want.trunc));
		if (m_tdata[135:132] !== 4'd0)
			flag_mismatch(field_msg("pad", m_tdata[135:132], 64'd0));
		if (m_tlast !== want.last)
			flag_mismatch(field_msg("last", m_tlast, want.last));
	endtask

	// ------------------------------------------------------------------------
	// driver: offers queued source bytes, runs each transfer through the lexer
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= 8'd0;
			s_tlast  <= 1'b0;
			gap_left = 0;
			lex_clear();
		end else begin
			if (s_tvalid && s_tready) begin
				lex_step(s_tdata, s_tlast);
				bytes_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left--;
					s_tvalid <= 1'b0;
				end else if (src_q.size() != 0 && !(src_q[0].drain && tok_q.size() != 0)) begin
					cur = src_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= cur.ch;
					s_tlast  <= cur.eoi;
					if ($urandom_range(0, 49) == 0)
						tx_calm = !tx_calm;
					gap_left = (cur.fast || tx_calm) ? 0 : $urandom_range(0, 11);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: takes tokens with random stalls and two long hold-offs
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				check_token();
				toks_seen++;
				if (toks_seen == 100 || toks_seen == 500)
					hold_left = LONG_HOLD;
				else
					hold_left = rx_calm ? 0 : $urandom_range(0, 11);
				if ($urandom_range(0, 39) == 0)
					rx_calm = !rx_calm;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		int unsigned rand_from;
		int          files;
		int          n_lines;

		// directed: every token kind except range, radix prefixes, octal stop, comment at end
		push_text("Q_z9:0xFf)09(\n");
		push_end();
		push_text(";c");
		push_end();
		push_end();
		push_text("0x,");
		push_src(8'hFF, 1'b0, 1'b0);
		push_end();
		push_src(8'h00, 1'b0, 1'b0);
		push_end();

		rand_from = src_q.size();
		files = 0;
		while (src_q.size() - rand_from < 1700) begin
			n_lines = $urandom_range(1, 6);
			for (int i = 0; i < n_lines; i++)
				push_line();
			case ($urandom_range(0, 3))
				0: push_word();
				1: push_number();
				2: push_text(";x");
				default: ;
			endcase
			push_end();
			files++;
			if (files % 25 == 5)
				drain_next = 1'b1;
		end
		bytes_total = src_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken != bytes_total)
			@(posedge clk);
		while (tok_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0 && tok_q.size() == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule
